// ----- rtl/bal_pkg.sv -----
// Shared types and constants of the block average logger.
// No dependencies; the top level block_average_logger uses this package.
`default_nettype none

package bal_pkg;

  // Block length and history depth
  localparam int AVG_LEN         = 10;
  localparam int HISTORY_ENTRIES = 64;

  // Field and state widths, channel count and result buffer depth
  localparam int SAMPLE_W = 10;
  localparam int MAXCT_W  = 16;
  localparam int SUM_W    = 16;
  localparam int PHASE_W  = 6;
  localparam int ENTRY_W  = 7;
  localparam int LOGENT_W = 6;
  localparam int NCHAN    = 5;
  localparam int MAX_RESULTS = 3;
  localparam int CNT_W    = 2;

  // Reciprocal for sum / AVG_LEN, exact for every 16-bit sum
  localparam int DIV_SHIFT = SUM_W + $clog2(AVG_LEN);
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam longint RECIP = ((64'd1 << DIV_SHIFT) + AVG_LEN - 1) / AVG_LEN;

  // Result kinds
  localparam logic [1:0] KIND_AVG   = 2'd0;
  localparam logic [1:0] KIND_HIST  = 2'd1;
  localparam logic [1:0] KIND_MAXCT = 2'd2;

  // History channel codes
  localparam logic [2:0] CH_LEFT  = 3'd0;
  localparam logic [2:0] CH_RIGHT = 3'd1;
  localparam logic [2:0] CH_FRONT = 3'd2;
  localparam logic [2:0] CH_STEER = 3'd3;
  localparam logic [2:0] CH_DRIVE = 3'd4;

  typedef struct packed {
    logic [9:0]  sample_left;
    logic [9:0]  sample_right;
    logic [9:0]  sample_front;
    logic [9:0]  steer_setting;
    logic [9:0]  drive_setting;
    logic [15:0] max_cycle_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] avg_left;
    logic [9:0] avg_right;
    logic [9:0] avg_front;
    logic [9:0] avg_steer;
    logic [9:0] avg_drive;
    logic [2:0] log_channel;
    logic [5:0] log_entry;
    logic       byte_high;
    logic [7:0] byte_value;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/block_average_logger.sv -----
// Block average logger: accumulators, block averages and history byte stream.
// Depends on bal_pkg for item types, kind and channel codes, and constants.
//
// Each input beat is one control tick with three sensor samples, two drive
// settings and the longest cycle time seen. The block adds the five values
// into 16-bit accumulators; on every tick whose phase is zero (one in AVG_LEN,
// the tick phase starts at one after reset) it reports the five block averages
// (sum / AVG_LEN, rounded down) and clears the accumulators. Setting the
// start_request register arms logging at the next average tick; from then on
// tick phases zero to nine each give one byte of the latest averages (left
// low, left high, right, front, steer, drive) for the current history entry,
// and when the last entry is done the two bytes of max_cycle_time follow once.
// A tick gives zero to three result beats, the final one flagged by last.
// Timing: a tick passes an accumulate stage, then a reciprocal-multiply stage
// that loads a three-entry result buffer, which shows its first result beat.
// The buffer drains one beat per cycle unless out_stall holds it; with the
// output not stalled, a new tick is accepted every cycle while ticks give at
// most one result, else a tick with results waits for the buffer's last beat.
`default_nettype none

module block_average_logger (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bal_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bal_pkg::out_item_t      out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_start_request
);

  // ---------------------------------------------------------------------------
  // Configuration register: always ready
  // ---------------------------------------------------------------------------
  logic start_request_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_request_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      start_request_r <= cfg_start_request;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: accumulate, tick phase and logging control
  // ---------------------------------------------------------------------------
  logic [bal_pkg::SUM_W-1:0]    sums_r   [bal_pkg::NCHAN];
  logic [bal_pkg::SUM_W-1:0]    sums_add [bal_pkg::NCHAN];
  logic [bal_pkg::SAMPLE_W-1:0] in_vals  [bal_pkg::NCHAN];
  logic [bal_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic [bal_pkg::ENTRY_W-1:0]  entry_r, entry_nxt;
  logic                         logging_started_r, start_taken_r;

  logic in_accept;
  logic is_avg, take_start, logging_now, active, do_byte, do_full, entry_inc;

  // Stage A to stage B register
  logic                          s1_valid_r;
  logic                          s1_avg_r, s1_byte_r, s1_full_r, s1_hi_r;
  logic [2:0]                    s1_ch_r;
  logic [bal_pkg::LOGENT_W-1:0]  s1_entry_r;
  logic [bal_pkg::SUM_W-1:0]     s1_sums_r [bal_pkg::NCHAN];
  logic [bal_pkg::MAXCT_W-1:0]   s1_maxct_r;
  logic                          s1_adv;
  logic [bal_pkg::CNT_W-1:0]     s1_n;

  assign in_vals[0] = in_item.sample_left;
  assign in_vals[1] = in_item.sample_right;
  assign in_vals[2] = in_item.sample_front;
  assign in_vals[3] = in_item.steer_setting;
  assign in_vals[4] = in_item.drive_setting;

  // Stage A takes a beat whenever stage B is empty or moves on this cycle
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    for (int i = 0; i < bal_pkg::NCHAN; i++) begin
      sums_add[i] = sums_r[i] + bal_pkg::SUM_W'(in_vals[i]);
    end
    is_avg      = (phase_r == '0);
    take_start  = is_avg && start_request_r && !start_taken_r;
    logging_now = logging_started_r || take_start;
    active      = logging_now &&
                  (entry_r < bal_pkg::ENTRY_W'(bal_pkg::HISTORY_ENTRIES));
    do_byte     = active && (phase_r < bal_pkg::PHASE_W'(10));
    entry_inc   = do_byte && (phase_r == bal_pkg::PHASE_W'(9));
    // The store fills on the tick that finishes its last entry
    do_full     = entry_inc &&
                  (entry_r == bal_pkg::ENTRY_W'(bal_pkg::HISTORY_ENTRIES - 1));
    entry_nxt   = entry_inc ? entry_r + 1'b1 : entry_r;
    phase_nxt   = (phase_r == bal_pkg::PHASE_W'(bal_pkg::AVG_LEN - 1)) ?
                  '0 : phase_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= bal_pkg::PHASE_W'(1 % bal_pkg::AVG_LEN);
      entry_r           <= '0;
      logging_started_r <= 1'b0;
      start_taken_r     <= 1'b0;
      for (int i = 0; i < bal_pkg::NCHAN; i++) begin
        sums_r[i] <= '0;
      end
    end else if (in_accept) begin
      phase_r <= phase_nxt;
      entry_r <= entry_nxt;
      if (take_start) begin
        logging_started_r <= 1'b1;
        start_taken_r     <= 1'b1;
      end
      // Clear the accumulators on the average tick
      for (int i = 0; i < bal_pkg::NCHAN; i++) begin
        sums_r[i] <= is_avg ? '0 : sums_add[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_avg_r   <= is_avg;
      s1_byte_r  <= do_byte;
      s1_full_r  <= do_full;
      s1_ch_r    <= 3'(phase_r >> 1);
      s1_hi_r    <= phase_r[0];
      s1_entry_r <= entry_r[bal_pkg::LOGENT_W-1:0];
      s1_maxct_r <= in_item.max_cycle_time;
      for (int i = 0; i < bal_pkg::NCHAN; i++) begin
        s1_sums_r[i] <= sums_add[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: divide by reciprocal multiply, pick bytes, build result beats
  // ---------------------------------------------------------------------------
  logic [bal_pkg::PROD_W-1:0]   prod     [bal_pkg::NCHAN];
  logic [bal_pkg::SAMPLE_W-1:0] quot     [bal_pkg::NCHAN];
  logic [bal_pkg::SAMPLE_W-1:0] avg_cur  [bal_pkg::NCHAN];
  logic [bal_pkg::SAMPLE_W-1:0] latest_r [bal_pkg::NCHAN];
  logic [bal_pkg::SAMPLE_W-1:0] sel_val;
  bal_pkg::out_item_t           item_avg, item_hist, item_lo, item_hi;
  bal_pkg::out_item_t           slot_ld  [bal_pkg::MAX_RESULTS];

  // Result buffer: slot 0 faces the output
  bal_pkg::out_item_t           res_r    [bal_pkg::MAX_RESULTS];
  logic [bal_pkg::CNT_W-1:0]    cnt_r;
  logic                         out_pop, buf_free;

  always_comb begin
    for (int i = 0; i < bal_pkg::NCHAN; i++) begin
      prod[i]    = bal_pkg::PROD_W'(s1_sums_r[i]) *
                   bal_pkg::PROD_W'(bal_pkg::RECIP);
      quot[i]    = prod[i][bal_pkg::DIV_SHIFT +: bal_pkg::SAMPLE_W];
      // Bypass the fresh averages on the average tick
      avg_cur[i] = s1_avg_r ? quot[i] : latest_r[i];
    end

    case (s1_ch_r)
      bal_pkg::CH_LEFT:  sel_val = avg_cur[0];
      bal_pkg::CH_RIGHT: sel_val = avg_cur[1];
      bal_pkg::CH_FRONT: sel_val = avg_cur[2];
      bal_pkg::CH_STEER: sel_val = avg_cur[3];
      bal_pkg::CH_DRIVE: sel_val = avg_cur[4];
      default:           sel_val = '0;
    endcase

    item_avg           = '0;
    item_avg.kind      = bal_pkg::KIND_AVG;
    item_avg.avg_left  = avg_cur[0];
    item_avg.avg_right = avg_cur[1];
    item_avg.avg_front = avg_cur[2];
    item_avg.avg_steer = avg_cur[3];
    item_avg.avg_drive = avg_cur[4];

    item_hist             = '0;
    item_hist.kind        = bal_pkg::KIND_HIST;
    item_hist.log_channel = s1_ch_r;
    item_hist.log_entry   = s1_entry_r;
    item_hist.byte_high   = s1_hi_r;
    item_hist.byte_value  = s1_hi_r ? 8'(sel_val >> 8) : sel_val[7:0];

    item_lo            = '0;
    item_lo.kind       = bal_pkg::KIND_MAXCT;
    item_lo.byte_value = s1_maxct_r[7:0];

    item_hi            = '0;
    item_hi.kind       = bal_pkg::KIND_MAXCT;
    item_hi.byte_high  = 1'b1;
    item_hi.byte_value = s1_maxct_r[15:8];

    // A full store only follows a history byte on a non-average tick
    s1_n = bal_pkg::CNT_W'(s1_avg_r) + bal_pkg::CNT_W'(s1_byte_r) +
           (s1_full_r ? bal_pkg::CNT_W'(2) : '0);

    slot_ld[0] = s1_avg_r ? item_avg  : item_hist;
    slot_ld[1] = s1_avg_r ? item_hist : item_lo;
    slot_ld[2] = item_hi;
    slot_ld[0].last = (s1_n == bal_pkg::CNT_W'(1));
    slot_ld[1].last = (s1_n == bal_pkg::CNT_W'(2));
    slot_ld[2].last = 1'b1;
  end

  assign out_valid = (cnt_r != '0);
  assign out_item  = res_r[0];
  assign out_pop   = out_valid && !out_stall;
  assign buf_free  = (cnt_r == '0) || ((cnt_r == bal_pkg::CNT_W'(1)) && out_pop);
  // A tick without results retires without waiting for the buffer
  assign s1_adv    = s1_valid_r && (buf_free || (s1_n == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bal_pkg::NCHAN; i++) begin
        latest_r[i] <= '0;
      end
    end else if (s1_adv && s1_avg_r) begin
      for (int i = 0; i < bal_pkg::NCHAN; i++) begin
        latest_r[i] <= quot[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (s1_adv && (s1_n != '0)) begin
      cnt_r <= s1_n;
    end else if (out_pop) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (s1_n != '0)) begin
      for (int i = 0; i < bal_pkg::MAX_RESULTS; i++) begin
        res_r[i] <= slot_ld[i];
      end
    end else if (out_pop) begin
      // Advance the buffer by one beat
      for (int i = 0; i < bal_pkg::MAX_RESULTS - 1; i++) begin
        res_r[i] <= res_r[i+1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bal_pkg::CNT_W'(bal_pkg::MAX_RESULTS))
    else $error("result buffer count out of range");

  a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
    entry_r <= bal_pkg::ENTRY_W'(bal_pkg::HISTORY_ENTRIES))
    else $error("history entry index beyond store");

  a_start_pair: assert property (@(posedge clk) disable iff (!rst_n)
    logging_started_r == start_taken_r)
    else $error("logging flags out of step");

  a_full_order: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_full_r) |-> (s1_byte_r && !s1_avg_r))
    else $error("store full without a closing history byte");

  a_last_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == bal_pkg::CNT_W'(1)) |-> res_r[0].last)
    else $error("final buffered beat not flagged last");

endmodule

`default_nettype wire

// ----- tb/tb_block_average_logger.sv -----
// Self-checking testbench for block_average_logger: directed and random ticks,
// with an in-bench tick predictor, random input gaps and random output stalls.
// Depends on bal_pkg (item types, kind codes, block constants) and the RTL.

module tb_block_average_logger;
  import bal_pkg::*;

  // Handshake pacing and run limits
  localparam int HOLD_OFF_AT     = 150;  // ticks taken before the long receiver hold-off
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int DROP_AT         = 200;  // logging ticks before the request is cleared
  localparam int DRAIN_CYCLES    = 8;    // settle time after the last due beat
  localparam int TAIL_CYCLES     = 20;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HIST_BYTES      = 2 * NCHAN;  // phases that write a history byte

  typedef struct {
    in_item_t  stim;
    bit        typed;  // expectation written out by hand below
    out_item_t want;
  } directed_row_t;

  logic      clk;
  logic      rst_n             = 1'b0;
  logic      in_valid          = 1'b0;
  logic      in_stall;
  in_item_t  in_item           = '0;
  logic      out_valid;
  logic      out_stall         = 1'b0;
  out_item_t out_item;
  logic      cfg_valid         = 1'b0;
  logic      cfg_ready;
  logic      cfg_start_request = 1'b0;

  // Predictor state: a private copy of the block's registers
  logic [PHASE_W-1:0]  tick_phase;
  logic [SUM_W-1:0]    acc [NCHAN];
  logic [SAMPLE_W-1:0] latest_avg [NCHAN];
  logic                logging_on;
  logic                start_taken;
  logic [ENTRY_W-1:0]  entry_idx;
  logic                start_req;

  out_item_t     tick_beats [$];  // beats of the tick just predicted
  out_item_t     beats_due [$];   // beats still awaited from the block, oldest first
  directed_row_t directed [$];

  int  fail_count  = 0;
  int  ticks_taken = 0;
  bit  tx_calm     = 1'b0;
  bit  rx_calm     = 1'b0;
  bit  hold_off_done = 1'b0;
  int  stall_left  = 0;
  int  rx_cycle    = 0;
  int  quiet_cycles = 0;

  block_average_logger DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_item           (in_item),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_item          (out_item),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_start_request (cfg_start_request)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Tick predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_model();
    tick_phase  = PHASE_W'(1 % AVG_LEN);
    for (int i = 0; i < NCHAN; i++) begin
      acc[i]        = '0;
      latest_avg[i] = '0;
    end
    logging_on  = 1'b0;
    start_taken = 1'b0;
    entry_idx   = '0;
    start_req   = 1'b0;
  endfunction

  // Advance the model by one tick and leave its beats in tick_beats.
  function automatic void compute_tick_beats(input in_item_t it);
    logic [SAMPLE_W-1:0] vals [NCHAN];
    logic [SAMPLE_W-1:0] v;
    logic [2:0]          ch;
    out_item_t           b;
    tick_beats.delete();
    vals[0] = it.sample_left;
    vals[1] = it.sample_right;
    vals[2] = it.sample_front;
    vals[3] = it.steer_setting;
    vals[4] = it.drive_setting;
    for (int i = 0; i < NCHAN; i++)
      acc[i] = acc[i] + SUM_W'(vals[i]);

    // Block boundary: latch averages, clear accumulators, maybe arm logging
    if (tick_phase == 0) begin
      for (int i = 0; i < NCHAN; i++) begin
        latest_avg[i] = SAMPLE_W'(acc[i] / AVG_LEN);
        acc[i]        = '0;
      end
      b = '0;
      b.kind      = KIND_AVG;
      b.avg_left  = latest_avg[0];
      b.avg_right = latest_avg[1];
      b.avg_front = latest_avg[2];
      b.avg_steer = latest_avg[3];
      b.avg_drive = latest_avg[4];
      tick_beats.push_back(b);
      if (start_req && !start_taken) begin
        start_taken = 1'b1;
        logging_on  = 1'b1;
      end
    end

    if (logging_on && entry_idx < HISTORY_ENTRIES) begin
      // Phases 0..9 walk the five channels, low byte then high byte
      if (tick_phase < HIST_BYTES) begin
        ch = 3'(tick_phase >> 1);
        v  = latest_avg[ch];
        b = '0;
        b.kind        = KIND_HIST;
        b.log_channel = ch;
        b.log_entry   = entry_idx[LOGENT_W-1:0];
        b.byte_high   = tick_phase[0];
        b.byte_value  = tick_phase[0] ? {6'b0, v[9:8]} : v[7:0];
        tick_beats.push_back(b);
        if (tick_phase == HIST_BYTES - 1)
          entry_idx = entry_idx + 1'b1;
      end
      // The tick that fills the store also logs the max cycle time, once
      if (entry_idx == HISTORY_ENTRIES) begin
        b = '0;
        b.kind       = KIND_MAXCT;
        b.byte_value = it.max_cycle_time[7:0];
        tick_beats.push_back(b);
        b.byte_high  = 1'b1;
        b.byte_value = it.max_cycle_time[15:8];
        tick_beats.push_back(b);
      end
    end

    if (tick_beats.size() > 0)
      tick_beats[tick_beats.size() - 1].last = 1'b1;
    tick_phase = (tick_phase + 1 >= AVG_LEN) ? '0 : tick_phase + 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75)
      return $urandom_range(1, 3);
    if (r < 95)
      return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Lean on the extremes a bit more than a flat draw would
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)
      return '0;
    if (r == 1)
      return '1;
    return SAMPLE_W'($urandom_range(0, 1023));
  endfunction

  function automatic in_item_t rand_tick();
    in_item_t it;
    int       r;
    it.sample_left   = rand_sample();
    it.sample_right  = rand_sample();
    it.sample_front  = rand_sample();
    it.steer_setting = rand_sample();
    it.drive_setting = rand_sample();
    r = $urandom_range(0, 9);
    it.max_cycle_time = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF :
                        MAXCT_W'($urandom_range(0, 65535));
    return it;
  endfunction

  function automatic in_item_t mk_tick(input int l, input int r, input int f, input int s,
                                       input int d, input logic [15:0] m);
    in_item_t it;
    it.sample_left    = SAMPLE_W'(l);
    it.sample_right   = SAMPLE_W'(r);
    it.sample_front   = SAMPLE_W'(f);
    it.steer_setting  = SAMPLE_W'(s);
    it.drive_setting  = SAMPLE_W'(d);
    it.max_cycle_time = m;
    return it;
  endfunction

  function automatic out_item_t mk_avg(input int l, input int r, input int f, input int s,
                                       input int d);
    out_item_t b;
    b = '0;
    b.kind      = KIND_AVG;
    b.avg_left  = SAMPLE_W'(l);
    b.avg_right = SAMPLE_W'(r);
    b.avg_front = SAMPLE_W'(f);
    b.avg_steer = SAMPLE_W'(s);
    b.avg_drive = SAMPLE_W'(d);
    b.last      = 1'b1;
    return b;
  endfunction

  function automatic void add_row(input in_item_t stim, input bit typed, input out_item_t want);
    directed_row_t row;
    row.stim  = stim;
    row.typed = typed;
    row.want  = want;
    directed.push_back(row);
  endfunction

  // Offer one tick, hold it until taken, then queue what it should produce.
  // Entered and left at a falling edge.
  task automatic send_tick(input in_item_t it, input bit typed, input out_item_t want);
    int gap;
    gap = (tx_calm || $urandom_range(0, 9) < 6) ? 0 : idle_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    compute_tick_beats(it);
    if (typed)
      beats_due.push_back(want);
    else
      foreach (tick_beats[i]) beats_due.push_back(tick_beats[i]);
    ticks_taken++;
    // Switch between paced and back-to-back stretches now and then
    if (ticks_taken % 40 == 0)
      tx_calm = ($urandom_range(0, 2) == 0);
    @(negedge clk);
  endtask

  // Let the block go idle, then write the start request register.
  task automatic write_start_request(input logic value);
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    // A tick without results may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid         <= 1'b1;
    cfg_start_request <= value;
    do @(posedge clk); while (!cfg_ready);
    start_req = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int logging_ticks;
    clear_model();

    // Block one: every sample and setting at its top value, average must be the top value.
    for (int i = 0; i < AVG_LEN; i++)
      add_row(mk_tick(1023, 1023, 1023, 1023, 1023, (i % 2) ? 16'hFFFF : 16'h0000),
              i == AVG_LEN - 1, mk_avg(1023, 1023, 1023, 1023, 1023));
    // Block two: one lone peak (rounds down), constants, and an all-zero channel.
    for (int i = 0; i < AVG_LEN; i++)
      add_row(mk_tick((i == 0) ? 1023 : 0, 9, 0, 1023, 1, (i % 2) ? 16'h0000 : 16'hFFFF),
              i == AVG_LEN - 1, mk_avg(102, 9, 0, 1023, 1));
    // Alternating and mixed bit patterns, left to the predictor
    add_row(mk_tick(10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 16'hAAAA), 1'b0, '0);
    add_row(mk_tick(10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 16'h5555), 1'b0, '0);
    add_row(mk_tick(10'h001, 10'h200, 10'h3FE, 10'h0FF, 10'h100, 16'h8001), 1'b0, '0);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_start_request(1'b0);
    foreach (directed[i])
      send_tick(directed[i].stim, directed[i].typed, directed[i].want);

    // Averages only, no logging yet
    repeat (50) send_tick(rand_tick(), 1'b0, '0);

    // Arm logging and run until the history store is full; partway through,
    // drop the request, which must not stop logging.
    write_start_request(1'b1);
    logging_ticks = 0;
    while (entry_idx != HISTORY_ENTRIES) begin
      send_tick(rand_tick(), 1'b0, '0);
      logging_ticks++;
      if (logging_ticks == DROP_AT)
        write_start_request(1'b0);
    end

    // Store full: a fresh request must not bring back any history beats
    write_start_request(1'b1);
    repeat (30) send_tick(rand_tick(), 1'b0, '0);

    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, calm stretches, and one long hold-off that
  // backs the block up until it stalls its input.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0)
      rx_calm <= ($urandom_range(0, 3) == 0);
    if (!hold_off_done && ticks_taken >= HOLD_OFF_AT) begin
      hold_off_done <= 1'b1;
      stall_left    <= HOLD_OFF_CYCLES - 1;
      out_stall     <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
      stall_left <= idle_gap() - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every accepted beat against the oldest due beat
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (beats_due.size() == 0) begin
        $error("result beat of kind %0d with nothing due", out_item.kind);
        fail_count++;
      end else begin
        want = beats_due.pop_front();
        check_field("kind",        want.kind,        out_item.kind);
        check_field("avg_left",    want.avg_left,    out_item.avg_left);
        check_field("avg_right",   want.avg_right,   out_item.avg_right);
        check_field("avg_front",   want.avg_front,   out_item.avg_front);
        check_field("avg_steer",   want.avg_steer,   out_item.avg_steer);
        check_field("avg_drive",   want.avg_drive,   out_item.avg_drive);
        check_field("log_channel", want.log_channel, out_item.log_channel);
        check_field("log_entry",   want.log_entry,   out_item.log_entry);
        check_field("byte_high",   want.byte_high,   out_item.byte_high);
        check_field("byte_value",  want.byte_value,  out_item.byte_value);
        check_field("last",        want.last,        out_item.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if no beat moves on any channel for too long
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
